### rtl/lsit_pkg.sv
// lsit_pkg: shared types and constants of the last-seen id table
// entry layout, transaction fields, controller states and register codes
// no dependencies
package lsit_pkg;

    localparam int ID_W      = 8;
    localparam int HASH_W    = 16;
    localparam int TICK_W    = 24;
    localparam int LIVE_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam int DEF_CHANNELS = 2;
    localparam int DEF_ENTRIES  = 8;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_PAD_W   = M_TDATA_W - LIVE_W - 1;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [ID_W-1:0]   OWN_ID_RESET  = '0;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd32768;
    localparam logic [ID_W-1:0]   ID_EMPTY      = '0;
    localparam logic [LIVE_W-1:0] LIVE_MAX      = '1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HASH_W-1:0] hash;
        logic [TICK_W-1:0] stamp;
        logic              stale;
    } entry_t;

    typedef struct packed {
        logic              action;
        logic              channel;
        logic [ID_W-1:0]   node_id;
        logic [HASH_W-1:0] content_hash;
        logic [TICK_W-1:0] now_ticks;
    } item_t;

    typedef struct packed {
        logic              fresh;
        logic [LIVE_W-1:0] live_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } state_t;

endpackage

### rtl/last_seen_id_table_core.sv
// Last-seen id table. Each channel keeps ENTRIES slots of {id, hash, stamp,
// timed-out mark} in a single-port-read entry memory; all slots are empty after
// reset. A record (tuser bit 0 low) or query (tuser bit 0 high) walks the
// selected channel's slots one per cycle through the memory read port. A
// transaction is accepted in ST_IDLE, walked in ST_SCAN, then written back in
// ST_WRITE or handed off in ST_RESULT. The hand-off stretches for as long as
// an earlier result still sits unaccepted in the output register. Records of
// id zero, of the own id, or of a channel beyond CHANNELS are dropped on
// acceptance and give no result. Every query gives exactly one result; a
// query on a channel beyond CHANNELS reports fresh = 0 and live_count = 0. A
// finished result waits in the output register while the next transaction is
// accepted. Configuration writes are always taken and must only happen while
// the block is idle.
// depends on lsit_pkg, lsit_ram, lsit_ctrl
module last_seen_id_table_core import lsit_pkg::*; #(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int ENTRIES  = DEF_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // node_id, content_hash, now_ticks
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action, channel
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fresh, live_count, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SLOTS  = CHANNELS * ENTRIES;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ID_W-1:0]   own_id_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic              m_tvalid_reg;
    result_t           m_res_reg;

    item_t             item;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;

    assign item.action       = s_tuser[0];
    assign item.channel      = s_tuser[1];
    assign item.node_id      = s_tdata[ID_W-1:0];
    assign item.content_hash = s_tdata[ID_W+HASH_W-1:ID_W];
    assign item.now_ticks    = s_tdata[ID_W+HASH_W+TICK_W-1:ID_W+HASH_W];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg  <= OWN_ID_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OWN_ID:  own_id_reg  <= cfg_data[ID_W-1:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data[TICK_W-1:0];
            endcase
        end
    end

    lsit_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lsit_ctrl #(
        .CHANNELS (CHANNELS),
        .ENTRIES  (ENTRIES),
        .SLOTS    (SLOTS),
        .SLOT_W   (SLOT_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .own_id        (own_id_reg),
        .timeout_ticks (timeout_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (item),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.live_count, m_res_reg.fresh};

endmodule

### rtl/lsit_ram.sv
// lsit_ram: entry memory, one write and one registered read port
// per-slot valid flags cleared at reset make unwritten slots read as empty
// depends on lsit_pkg
module lsit_ram import lsit_pkg::*; #(
    parameter int DEPTH  = DEF_CHANNELS * DEF_ENTRIES,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rd_q_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

### rtl/lsit_ctrl.sv
// lsit_ctrl: sequencer that walks one channel's entries through the memory
// evaluates match, empty, timed-out and oldest slots, writes back, builds results
// depends on lsit_pkg
module lsit_ctrl import lsit_pkg::*; #(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int SLOTS    = CHANNELS * ENTRIES,
    parameter int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ID_W-1:0]   own_id,
    input  logic [TICK_W-1:0] timeout_ticks,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             in_item,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              rd_en,
    output logic [SLOT_W-1:0] rd_addr,
    input  entry_t            rd_data,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_addr,
    output entry_t            wr_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SAT_W = CNT_W + LIVE_W;

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [SLOT_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                hit_reg, hit_next;
    logic                same_reg, same_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]    empty_idx_reg, empty_idx_next;
    logic                stale_found_reg, stale_found_next;
    logic [IDX_W-1:0]    stale_idx_reg, stale_idx_next;
    logic [TICK_W-1:0]   oldest_age_reg, oldest_age_next;
    logic [IDX_W-1:0]    oldest_idx_reg, oldest_idx_next;
    logic [CNT_W-1:0]    live_reg, live_next;

    logic [IDX_W-1:0]    dat_idx;
    logic [TICK_W-1:0]   age;
    logic                chan_ok;
    logic [SAT_W-1:0]    live_wide;
    entry_t              fill;

    assign dat_idx   = IDX_W'(cnt_reg - CNT_W'(1));
    assign age       = item_reg.now_ticks - rd_data.stamp;
    assign chan_ok   = int'(in_item.channel) < CHANNELS;
    assign live_wide = SAT_W'(live_reg);

    always_comb begin
        fill.id    = item_reg.node_id;
        fill.hash  = item_reg.content_hash;
        fill.stamp = item_reg.now_ticks;
        fill.stale = 1'b0;
    end

    assign res.fresh      = hit_reg || (live_reg == CNT_W'(ENTRIES));
    assign res.live_count = (live_wide > SAT_W'(LIVE_MAX)) ? LIVE_MAX
                                                           : live_wide[LIVE_W-1:0];

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        base_next        = base_reg;
        cnt_next         = cnt_reg;
        hit_next         = hit_reg;
        same_next        = same_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        stale_found_next = stale_found_reg;
        stale_idx_next   = stale_idx_reg;
        oldest_age_next  = oldest_age_reg;
        oldest_idx_next  = oldest_idx_reg;
        live_next        = live_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = base_reg + SLOT_W'(cnt_reg[IDX_W-1:0]);
        wr_en            = 1'b0;
        wr_addr          = base_reg + SLOT_W'(dat_idx);
        wr_data          = fill;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next        = in_item;
                    base_next        = in_item.channel ? SLOT_W'(ENTRIES) : '0;
                    cnt_next         = '0;
                    hit_next         = 1'b0;
                    same_next        = 1'b0;
                    hit_idx_next     = '0;
                    empty_found_next = 1'b0;
                    empty_idx_next   = '0;
                    stale_found_next = 1'b0;
                    stale_idx_next   = '0;
                    oldest_age_next  = '0;
                    oldest_idx_next  = '0;
                    live_next        = '0;
                    priority if (!chan_ok) begin
                        state_next = (in_item.action == ACT_QUERY) ? ST_RESULT : ST_IDLE;
                    end else if (in_item.action == ACT_RECORD &&
                                 (in_item.node_id == ID_EMPTY ||
                                  in_item.node_id == own_id)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en    = cnt_reg < CNT_W'(ENTRIES);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0) begin
                    if (item_reg.action == ACT_RECORD) begin
                        if (!hit_reg && rd_data.id == item_reg.node_id) begin
                            hit_next     = 1'b1;
                            hit_idx_next = dat_idx;
                            same_next    = rd_data.hash == item_reg.content_hash;
                        end
                        if (!empty_found_reg && rd_data.id == ID_EMPTY) begin
                            empty_found_next = 1'b1;
                            empty_idx_next   = dat_idx;
                        end
                        if (!stale_found_reg && rd_data.stale) begin
                            stale_found_next = 1'b1;
                            stale_idx_next   = dat_idx;
                        end
                        if (age > oldest_age_reg) begin
                            oldest_age_next = age;
                            oldest_idx_next = dat_idx;
                        end
                    end else if (rd_data.id != ID_EMPTY && !rd_data.stale) begin
                        if (age > timeout_ticks) begin
                            wr_en         = 1'b1;
                            wr_data       = rd_data;
                            wr_data.stale = 1'b1;
                        end else begin
                            live_next = live_reg + CNT_W'(1);
                            if (rd_data.id == item_reg.node_id) begin
                                hit_next = 1'b1;
                            end
                        end
                    end
                end
                if (cnt_reg == CNT_W'(ENTRIES)) begin
                    state_next = (item_reg.action == ACT_QUERY) ? ST_RESULT : ST_WRITE;
                end
            end
            ST_WRITE: begin
                priority if (hit_reg) begin
                    wr_en   = !same_reg;
                    wr_addr = base_reg + SLOT_W'(hit_idx_reg);
                end else if (empty_found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = base_reg + SLOT_W'(empty_idx_reg);
                end else if (stale_found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = base_reg + SLOT_W'(stale_idx_reg);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = base_reg + SLOT_W'(oldest_idx_reg);
                end
                state_next = ST_IDLE;
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        base_reg        <= base_next;
        cnt_reg         <= cnt_next;
        hit_reg         <= hit_next;
        same_reg        <= same_next;
        hit_idx_reg     <= hit_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        stale_found_reg <= stale_found_next;
        stale_idx_reg   <= stale_idx_next;
        oldest_age_reg  <= oldest_age_next;
        oldest_idx_reg  <= oldest_idx_next;
        live_reg        <= live_next;
    end

endmodule

### rtl/lsit_checker.sv
// lsit_checker: port-level checks on the result channel of the id table
// bound to last_seen_id_table_core; depends on lsit_pkg
module lsit_checker import lsit_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result dropped");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result changed");

    a_fresh_needs_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[LIVE_W:1] != '0)
        else $error("fresh reported with no live entry");

    a_live_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> int'(m_tdata[LIVE_W:1]) <= ENTRIES)
        else $error("live count above channel size");

endmodule

bind last_seen_id_table_core lsit_checker #(
    .ENTRIES (ENTRIES)
) u_lsit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb_top.sv
// tb_top: self-checking testbench for last_seen_id_table_core
// predicts table contents and query answers, drives both streams with random stalls
// depends on lsit_pkg and the core rtl
module tb_top import lsit_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX     = 19;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 2 * (DEF_ENTRIES + 3) + 4;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    last_seen_id_table_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow copy of the table and registers
    entry_t            shadow [DEF_CHANNELS][DEF_ENTRIES];
    logic [ID_W-1:0]   my_id  = OWN_ID_RESET;
    logic [TICK_W-1:0] expiry = TIMEOUT_RESET;

    result_t pending_answers [$];
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      src_gap_max  = GAP_MAX;
    int      sink_gap_max = GAP_MAX;
    int      hold_len     = 0;
    logic [TICK_W-1:0] tick_now = '0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [TICK_W-1:0] ticks_since(logic [TICK_W-1:0] now,
                                                      logic [TICK_W-1:0] stamp);
        return now - stamp;
    endfunction

    function automatic void claim_slot(int ch, int slot, logic [ID_W-1:0] id,
                                       logic [HASH_W-1:0] hash, logic [TICK_W-1:0] now);
        shadow[ch][slot].id    = id;
        shadow[ch][slot].hash  = hash;
        shadow[ch][slot].stamp = now;
        shadow[ch][slot].stale = 1'b0;
    endfunction

    function automatic void note_sighting(int ch, logic [ID_W-1:0] id,
                                          logic [HASH_W-1:0] hash, logic [TICK_W-1:0] now);
        int                pick;
        logic [TICK_W-1:0] oldest;
        logic [TICK_W-1:0] age;
        pick = 0;
        oldest = '0;
        if (id == ID_EMPTY || id == my_id)
            return;
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (shadow[ch][i].id == id) begin
                if (shadow[ch][i].hash != hash)
                    claim_slot(ch, i, id, hash, now);
                return;
            end
        end
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (shadow[ch][i].id == ID_EMPTY) begin
                claim_slot(ch, i, id, hash, now);
                return;
            end
        end
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (shadow[ch][i].stale) begin
                pick = i;
                break;
            end
            age = ticks_since(now, shadow[ch][i].stamp);
            if (age > oldest) begin
                oldest = age;
                pick = i;
            end
        end
        claim_slot(ch, pick, id, hash, now);
    endfunction

    function automatic result_t freshness_of(int ch, logic [ID_W-1:0] id,
                                             logic [TICK_W-1:0] now);
        result_t r;
        int      live;
        logic    hit;
        live = 0;
        hit = 1'b0;
        for (int i = 0; i < DEF_ENTRIES; i++) begin
            if (shadow[ch][i].id == ID_EMPTY || shadow[ch][i].stale)
                continue;
            if (ticks_since(now, shadow[ch][i].stamp) > expiry) begin
                shadow[ch][i].stale = 1'b1;
                continue;
            end
            live++;
            if (shadow[ch][i].id == id)
                hit = 1'b1;
        end
        r.fresh = hit || (live == DEF_ENTRIES);
        r.live_count = (live > LIVE_MAX) ? LIVE_MAX : live[LIVE_W-1:0];
        return r;
    endfunction

    function automatic item_t build_item(logic action, logic channel, logic [ID_W-1:0] id,
                                         logic [HASH_W-1:0] hash, logic [TICK_W-1:0] now);
        item_t it;
        it.action = action;
        it.channel = channel;
        it.node_id = id;
        it.content_hash = hash;
        it.now_ticks = now;
        return it;
    endfunction

    // mostly a small id pool on an advancing tick, some fully random noise
    function automatic item_t random_item(int unsigned span);
        item_t it;
        it.action = ($urandom_range(0, 99) < 45) ? ACT_QUERY : ACT_RECORD;
        it.channel = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            it.node_id = ID_W'($urandom);
            it.content_hash = HASH_W'($urandom);
            it.now_ticks = TICK_W'($urandom);
        end else begin
            it.node_id = ID_W'($urandom_range(1, 12));
            if ($urandom_range(0, 19) == 0)
                it.node_id = my_id;
            it.content_hash = HASH_W'($urandom_range(0, 3));
            tick_now = tick_now + TICK_W'($urandom_range(0, span));
            it.now_ticks = tick_now;
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.now_ticks, it.content_hash, it.node_id};
        s_tuser  <= {it.channel, it.action};
        do @(posedge aclk); while (!s_tready);
        if (it.action == ACT_QUERY)
            pending_answers.push_back(freshness_of(it.channel, it.node_id, it.now_ticks));
        else
            note_sighting(it.channel, it.node_id, it.content_hash, it.now_ticks);
    endtask

    // stop offering, let every answer come back, then cover a trailing record
    task automatic wait_settled();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_OWN_ID:  my_id = value[ID_W-1:0];
            CFG_TIMEOUT: expiry = value[TICK_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_own_id(logic [ID_W-1:0] id);
        logic [CFG_W-1:0] value;
        value = CFG_W'($urandom);
        value[ID_W-1:0] = id;
        write_reg(CFG_OWN_ID, value);
    endtask

    // reset registers: empty table, id zero, wrapped age, same hash, refresh
    task automatic test_table_basics();
        src_gap_max = GAP_MAX;
        sink_gap_max = GAP_MAX;
        send_item(build_item(ACT_QUERY, 1'b0, ID_EMPTY, 16'h0000, 24'd0));
        send_item(build_item(ACT_RECORD, 1'b0, ID_EMPTY, 16'h1234, 24'd10));
        send_item(build_item(ACT_RECORD, 1'b0, 8'hFF, 16'hFFFF, 24'hFFFFFF));
        send_item(build_item(ACT_QUERY, 1'b0, 8'hFF, 16'h0000, 24'd32767));
        send_item(build_item(ACT_RECORD, 1'b0, 8'hFF, 16'hFFFF, 24'd30000));
        send_item(build_item(ACT_QUERY, 1'b0, 8'hFF, 16'h0000, 24'd32768));
        send_item(build_item(ACT_RECORD, 1'b0, 8'hFF, 16'h0001, 24'd40000));
        send_item(build_item(ACT_QUERY, 1'b0, 8'hFF, 16'h0000, 24'd40000));
        // full channel, oldest replaced, then timed-out replaced
        for (int i = 1; i <= DEF_ENTRIES; i++)
            send_item(build_item(ACT_RECORD, 1'b1, ID_W'(i), HASH_W'(i), TICK_W'(100 * i)));
        send_item(build_item(ACT_QUERY, 1'b1, 8'd200, 16'h0000, 24'd1000));
        send_item(build_item(ACT_RECORD, 1'b1, 8'd9, 16'd9, 24'd2000));
        send_item(build_item(ACT_QUERY, 1'b1, 8'd1, 16'h0000, 24'd2000));
        send_item(build_item(ACT_QUERY, 1'b1, 8'd9, 16'h0000, 24'd100000));
        send_item(build_item(ACT_RECORD, 1'b1, 8'd10, 16'd10, 24'd100001));
        send_item(build_item(ACT_QUERY, 1'b1, 8'd10, 16'h0000, 24'd100002));
        wait_settled();
    endtask

    // own id ignored, zero timeout, largest timeout with all ages equal
    task automatic test_register_extremes();
        wait_settled();
        write_own_id(8'hFF);
        write_reg(CFG_TIMEOUT, '0);
        send_item(build_item(ACT_RECORD, 1'b0, 8'hFF, 16'hBEEF, 24'd40001));
        send_item(build_item(ACT_QUERY, 1'b0, 8'hFF, 16'h0000, 24'd40001));
        wait_settled();
        write_own_id(8'h00);
        write_reg(CFG_TIMEOUT, '1);
        for (int i = 20; i <= 28; i++)
            send_item(build_item(ACT_RECORD, 1'b0, ID_W'(i), HASH_W'(i), 24'd777));
        send_item(build_item(ACT_QUERY, 1'b0, 8'd20, 16'h0000, 24'd776));
        wait_settled();
    endtask

    task automatic run_traffic_phase(logic [ID_W-1:0] own, logic [TICK_W-1:0] limit,
                                     int unsigned span, int count);
        wait_settled();
        write_own_id(own);
        write_reg(CFG_TIMEOUT, CFG_W'(limit));
        tick_now = TICK_W'($urandom);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                src_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
                sink_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
            end
            send_item(random_item(span));
        end
        wait_settled();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(ID_W'($urandom_range(1, 12)), 24'd200, 60, 80);
        run_traffic_phase(ID_W'($urandom), 24'd0, 2, 80);
        run_traffic_phase(8'd3, 24'hFFFFFF, 1 << 21, 80);
        run_traffic_phase(OWN_ID_RESET, TIMEOUT_RESET, 6000, 80);
        run_traffic_phase(ID_W'($urandom_range(1, 12)), 24'd1500, 400, 80);
    endtask

    // receiver holds off while queries keep coming, then the sender drains
    task automatic test_backpressure();
        item_t it;
        src_gap_max = 0;
        sink_gap_max = GAP_MAX;
        hold_len = HOLD_CYCLES;
        for (int n = 0; n < 16; n++) begin
            it = random_item(50);
            if (n % 2 == 0)
                it.action = ACT_QUERY;
            send_item(it);
        end
        wait_settled();
    endtask

    initial begin : result_sink
        int pause;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_len != 0) begin
                pause = hold_len;
                hold_len = 0;
            end else begin
                pause = $urandom_range(0, sink_gap_max);
            end
            if (pause != 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin : answer_checker
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.fresh = m_tdata[0];
            got.live_count = m_tdata[LIVE_W:1];
            if (pending_answers.size() == 0) begin
                note_mismatch($sformatf("result with no pending query: fresh %0d live_count %0d",
                                        got.fresh, got.live_count));
            end else begin
                want = pending_answers.pop_front();
                if (got.fresh != want.fresh)
                    note_mismatch($sformatf("fresh expected %0d, got %0d",
                                            want.fresh, got.fresh));
                if (got.live_count != want.live_count)
                    note_mismatch($sformatf("live_count expected %0d, got %0d",
                                            want.live_count, got.live_count));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : main_sequence
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        for (int c = 0; c < DEF_CHANNELS; c++)
            for (int i = 0; i < DEF_ENTRIES; i++)
                shadow[c][i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_basics();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
